[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising clock, off while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/hmng_pkg.sv]
`timescale 1ns / 1ps
package hmng_pkg;
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;
    localparam int QSCALE       = 32767;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLAN,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_RD_WAIT,
        ST_DIFF,
        ST_COMP,
        ST_COMP_WAIT,
        ST_OUT
    } t_state;

    // Start command and result of the shared rounding/normalize unit
    typedef struct packed {
        logic        start;
        logic [9:0]  mag;   // |a|, at most 510
        logic [18:0] s;     // dr^2 + 4 + dc^2
    } t_qcmd;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [14:0] q;
    } t_qrsp;
endpackage

[hdl/hmng_qunit.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Finds the largest q <= 32767 with (2q-1)^2 * s <= (2*32767*mag)^2 by
// binary search; each probe squares the candidate, then scales and compares.
module hmng_qunit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hmng_pkg::t_qcmd    i_cmd,
    output hmng_pkg::t_qrsp    o_rsp
);
    logic [14:0] r_lo, n_lo, r_hi, n_hi;
    logic [18:0] r_s, n_s;
    logic [49:0] r_t, n_t;
    logic        r_busy, n_busy, r_done, n_done, r_phase, n_phase;
    logic [31:0] r_dsq, n_dsq;
    logic [15:0] w_mid;
    logic [15:0] w_d;
    logic [50:0] w_lhs;

    assign w_mid = ({1'b0, r_lo} + {1'b0, r_hi} + 16'd1) >> 1;
    assign w_d   = {w_mid[14:0], 1'b0} - 16'd1;
    assign w_lhs = {19'd0, r_dsq} * {32'd0, r_s};

    always_comb begin
        n_lo = r_lo; n_hi = r_hi; n_s = r_s; n_t = r_t;
        n_busy = r_busy; n_done = 1'b0; n_phase = r_phase; n_dsq = r_dsq;
        if (i_cmd.start && !r_busy) begin
            n_lo = '0;
            n_hi = 15'(hmng_pkg::QSCALE);
            n_s  = i_cmd.s;
            n_t  = 50'(25'(2 * hmng_pkg::QSCALE) * 25'(i_cmd.mag));
            n_busy = 1'b1;
            n_phase = 1'b0;
        end else if (r_busy) begin
            if (r_phase == 1'b0) begin
                if (r_lo == r_hi) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_dsq = w_d * w_d;
                    n_phase = 1'b1;
                end
            end else begin
                if (w_lhs <= {1'b0, r_t}) n_lo = w_mid[14:0];
                else n_hi = w_mid[14:0] - 15'd1;
                n_phase = 1'b0;
            end
        end
    end

    // square the bound once at start
    logic r_sq_pend;
    logic [24:0] r_tm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_phase <= 1'b0; r_sq_pend <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_phase <= n_phase;
            r_sq_pend <= i_cmd.start && !r_busy;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_s <= n_s; r_dsq <= n_dsq;
        if (i_cmd.start && !r_busy) r_tm <= n_t[24:0];
        if (r_sq_pend) r_t <= {25'd0, r_tm} * {25'd0, r_tm};
        else r_t <= r_t;
    end

    assign o_rsp.busy = r_busy || r_sq_pend;
    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_lo;

    `ASSERT_IMPL(a_q_range, i_clk, i_rst_n, r_busy, r_lo <= r_hi, "qunit: lo passed hi")
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "qunit: done held")
endmodule

[hdl/hmng_store.sv]
`timescale 1ns / 1ps
// Three-row line store, a single port with one address per cycle, registered read (old data on a write).
module hmng_store #(
    parameter int MAX_COLS = hmng_pkg::MAX_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [1:0]                    i_row,
    input  logic [$clog2(MAX_COLS+1)-1:0] i_col,
    input  logic [7:0]                    i_wdata,
    output logic [7:0]                    o_rdata
);
    localparam int AW = $clog2(3 * MAX_COLS);
    logic [7:0] r_mem [3 * MAX_COLS];
    logic [AW-1:0] w_addr;

    assign w_addr = AW'(i_row) * AW'(MAX_COLS) + AW'(i_col);

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[w_addr] <= i_wdata;
        o_rdata <= r_mem[w_addr];
    end
endmodule

[hdl/heightmap_normal_generator_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Heightmap normal generator: takes one 8-bit height per transfer in row-major
// order and returns zero to three unit normals (Q1.15) with their point row
// and column; tlast marks the final normal of a sample. One sample is handled
// at a time, and no new height is taken until all of its normals have been
// accepted by the receiver: each normal takes four line-store reads and three
// runs of the shared binary-search normalize unit. The line store holds three
// rows and needs no clearing after reset.
module heightmap_normal_generator_core #(
    parameter int MAX_COLS = hmng_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hmng_pkg::MAX_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // height[7:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // normal_x[15:0], normal_y[31:16], normal_z[47:32], point_row[57:48],
    // point_col[67:58], zero fill [71:68]
    output logic [71:0]                      m_axis_tdata,
    output logic                             m_axis_tlast,   // last_of_item
    input  logic                             i_cfg_we,
    input  logic [hmng_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hmng_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int CW = $clog2(MAX_COLS+1);
    localparam int RW = $clog2(MAX_ROWS+1);

    hmng_pkg::t_state r_state, n_state;
    logic [10:0] r_map_rows, r_map_cols;
    logic        r_inv;
    logic [RW-1:0] r_row, n_row, r_r, n_r;
    logic [CW-1:0] r_col, n_col, r_c, n_c;
    logic [1:0]  r_row_slot, n_row_slot;  // store row of r_row (row mod 3)
    logic [1:0]  r_rs, n_rs;              // store row of r_r
    logic [1:0]  r_ps, n_ps;              // store row of r_pr
    logic [7:0]  r_h;
    logic [1:0]  r_todo, n_todo;     // remaining normals, bit0 = (r,c-1), bit1 = (r,c)
    logic        r_first, n_first;   // (r-1,c) still pending
    logic [RW-1:0] r_pr, n_pr;
    logic [CW-1:0] r_pc, n_pc;
    logic        r_last, n_last;
    logic [7:0]  r_ha, r_hb, r_hc;
    logic signed [9:0] r_dr, r_dc;
    logic [1:0]  r_k, n_k;
    logic [14:0] r_q [3];
    logic [71:0] w_tdata;
    logic        w_tlast;

    logic [RW-1:0] w_rows;
    logic [CW-1:0] w_cols;
    assign w_rows = (r_map_rows == 11'd0) ? RW'(1) :
                    ({21'd0, r_map_rows} > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(r_map_rows);
    assign w_cols = (r_map_cols == 11'd0) ? CW'(1) :
                    ({21'd0, r_map_cols} > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(r_map_cols);

    function automatic logic [1:0] f_inc3(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] f_dec3(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    // neighbor store rows and columns for the current point
    logic [1:0]    w_sa1, w_sa0;
    logic [CW-1:0] w_ca0, w_ca1;
    logic          w_rsing, w_csing, w_rdbl, w_cdbl;
    always_comb begin
        w_rsing = (w_rows == RW'(1));
        w_csing = (w_cols == CW'(1));
        w_rdbl = 1'b1; w_cdbl = 1'b1;
        if (r_pr == '0) begin w_sa1 = f_inc3(r_ps); w_sa0 = r_ps; end
        else if (r_pr == w_rows - RW'(1)) begin w_sa1 = r_ps; w_sa0 = f_dec3(r_ps); end
        else begin w_sa1 = f_inc3(r_ps); w_sa0 = f_dec3(r_ps); w_rdbl = 1'b0; end
        if (r_pc == '0) begin w_ca1 = CW'(1); w_ca0 = '0; end
        else if (r_pc == w_cols - CW'(1)) begin w_ca1 = r_pc; w_ca0 = r_pc - CW'(1); end
        else begin w_ca1 = r_pc + CW'(1); w_ca0 = r_pc - CW'(1); w_cdbl = 1'b0; end
    end

    // store port
    logic          w_we;
    logic [1:0]    w_srow;
    logic [CW-1:0] w_scol;
    logic [7:0]    w_rd;
    always_comb begin
        w_we = 1'b0; w_srow = r_ps; w_scol = r_pc;
        unique case (r_state)
            hmng_pkg::ST_PLAN: begin w_we = 1'b1; w_srow = r_rs; w_scol = r_c; end
            hmng_pkg::ST_RD_A: begin w_srow = w_sa1; w_scol = r_pc; end
            hmng_pkg::ST_RD_B: begin w_srow = w_sa0; w_scol = r_pc; end
            hmng_pkg::ST_RD_C: begin w_srow = r_ps; w_scol = w_ca1; end
            hmng_pkg::ST_RD_D: begin w_srow = r_ps; w_scol = w_ca0; end
            default: ;
        endcase
    end

    hmng_store #(.MAX_COLS(MAX_COLS)) u_store (
        .i_clk(i_clk), .i_we(w_we), .i_row(w_srow), .i_col(w_scol),
        .i_wdata(r_h), .o_rdata(w_rd)
    );

    // shared normalize unit
    hmng_pkg::t_qcmd w_cmd;
    hmng_pkg::t_qrsp w_rsp;
    logic signed [9:0] w_a;
    logic [8:0]  w_mdr, w_mdc;
    logic [18:0] w_s;
    always_comb begin
        w_mdr = r_dr[9] ? 9'(-r_dr) : 9'(r_dr);
        w_mdc = r_dc[9] ? 9'(-r_dc) : 9'(r_dc);
        w_s = 19'({9'd0, w_mdr} * {9'd0, w_mdr}) + 19'd4 +
              19'({9'd0, w_mdc} * {9'd0, w_mdc});
        unique case (r_k)
            2'd0: w_a = -r_dr;
            2'd1: w_a = 10'sd2;
            default: w_a = r_dc;
        endcase
        w_cmd.start = (r_state == hmng_pkg::ST_COMP);
        w_cmd.mag   = w_a[9] ? 10'(-w_a) : w_a;
        w_cmd.s     = w_s;
    end

    hmng_qunit u_qunit (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_rsp(w_rsp));

    function automatic logic [15:0] f_sign(input logic [14:0] q, input logic neg);
        return neg ? 16'(-{1'b0, q}) : {1'b0, q};
    endfunction

    logic signed [9:0] w_dr, w_dc;
    logic w_nx, w_nz;
    always_comb begin
        w_dr = w_rsing ? 10'sd0 : w_rdbl ? ((10'(r_ha) - 10'(r_hb)) <<< 1) : (10'(r_ha) - 10'(r_hb));
        w_dc = w_csing ? 10'sd0 : w_cdbl ? ((10'(r_hc) - 10'(w_rd)) <<< 1) : (10'(r_hc) - 10'(w_rd));
        w_nx = (r_dr > 0) ^ r_inv;
        w_nz = (r_dc < 0) ^ r_inv;
    end

    always_comb begin
        n_state = r_state; n_row = r_row; n_col = r_col; n_r = r_r; n_c = r_c;
        n_row_slot = r_row_slot; n_rs = r_rs; n_ps = r_ps;
        n_todo = r_todo; n_first = r_first; n_pr = r_pr; n_pc = r_pc; n_last = r_last;
        n_k = r_k;
        unique case (r_state)
            hmng_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (r_row >= w_rows || r_col >= w_cols) begin
                        n_r = '0; n_c = '0; n_rs = 2'd0;
                    end else begin
                        n_r = r_row; n_c = r_col; n_rs = r_row_slot;
                    end
                    n_state = hmng_pkg::ST_PLAN;
                end
            end
            hmng_pkg::ST_PLAN: begin
                n_first = (r_r != '0);
                n_todo[0] = (r_r == w_rows - RW'(1)) && (r_c != '0);
                n_todo[1] = (r_r == w_rows - RW'(1)) && (r_c == w_cols - CW'(1));
                if (r_c + CW'(1) == w_cols) begin
                    n_col = '0;
                    if (r_r + RW'(1) == w_rows) begin
                        n_row = '0; n_row_slot = 2'd0;
                    end else begin
                        n_row = r_r + RW'(1); n_row_slot = f_inc3(r_rs);
                    end
                end else begin
                    n_col = r_c + CW'(1); n_row = r_r; n_row_slot = r_rs;
                end
                n_state = hmng_pkg::ST_RD_WAIT;
            end
            hmng_pkg::ST_RD_WAIT: begin
                // pick next point or finish
                if (r_first) begin
                    n_pr = r_r - RW'(1); n_pc = r_c; n_ps = f_dec3(r_rs); n_first = 1'b0;
                    n_last = (r_todo == 2'b00); n_state = hmng_pkg::ST_RD_A;
                end else if (r_todo[0]) begin
                    n_pr = r_r; n_pc = r_c - CW'(1); n_ps = r_rs; n_todo[0] = 1'b0;
                    n_last = !r_todo[1]; n_state = hmng_pkg::ST_RD_A;
                end else if (r_todo[1]) begin
                    n_pr = r_r; n_pc = r_c; n_ps = r_rs; n_todo[1] = 1'b0;
                    n_last = 1'b1; n_state = hmng_pkg::ST_RD_A;
                end else begin
                    n_state = hmng_pkg::ST_IDLE;
                end
            end
            hmng_pkg::ST_RD_A: n_state = hmng_pkg::ST_RD_B;
            hmng_pkg::ST_RD_B: n_state = hmng_pkg::ST_RD_C;
            hmng_pkg::ST_RD_C: n_state = hmng_pkg::ST_RD_D;
            hmng_pkg::ST_RD_D: n_state = hmng_pkg::ST_DIFF;
            hmng_pkg::ST_DIFF: begin n_k = 2'd0; n_state = hmng_pkg::ST_COMP; end
            hmng_pkg::ST_COMP: n_state = hmng_pkg::ST_COMP_WAIT;
            hmng_pkg::ST_COMP_WAIT: begin
                if (w_rsp.done) begin
                    if (r_k == 2'd2) n_state = hmng_pkg::ST_OUT;
                    else begin n_k = r_k + 2'd1; n_state = hmng_pkg::ST_COMP; end
                end
            end
            hmng_pkg::ST_OUT: if (m_axis_tready) n_state = hmng_pkg::ST_RD_WAIT;
            default: n_state = hmng_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hmng_pkg::ST_IDLE;
            r_row <= '0; r_col <= '0; r_row_slot <= 2'd0;
            r_map_rows <= 11'd1024; r_map_cols <= 11'd1024; r_inv <= 1'b0;
            r_first <= 1'b0; r_todo <= '0;
        end else begin
            r_state <= n_state; r_row <= n_row; r_col <= n_col; r_row_slot <= n_row_slot;
            r_first <= n_first; r_todo <= n_todo;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hmng_pkg::REG_MAP_ROWS: r_map_rows <= i_cfg_data;
                    hmng_pkg::REG_MAP_COLS: r_map_cols <= i_cfg_data;
                    hmng_pkg::REG_INVERT:   r_inv <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        r_r <= n_r; r_c <= n_c; r_pr <= n_pr; r_pc <= n_pc; r_last <= n_last;
        r_rs <= n_rs; r_ps <= n_ps; r_k <= n_k;
        if (r_state == hmng_pkg::ST_IDLE) r_h <= s_axis_tdata;
        // read data arrives in the cycle after its address
        if (r_state == hmng_pkg::ST_RD_B) r_ha <= w_rd;
        if (r_state == hmng_pkg::ST_RD_C) r_hb <= w_rd;
        if (r_state == hmng_pkg::ST_RD_D) r_hc <= w_rd;
        if (r_state == hmng_pkg::ST_DIFF) begin r_dr <= w_dr; r_dc <= w_dc; end
        if (r_state == hmng_pkg::ST_COMP_WAIT && w_rsp.done) r_q[r_k] <= w_rsp.q;
    end

    always_comb begin
        w_tdata = '0;
        w_tdata[15:0]  = f_sign(r_q[0], w_nx);
        w_tdata[31:16] = f_sign(r_q[1], r_inv);
        w_tdata[47:32] = f_sign(r_q[2], w_nz);
        w_tdata[57:48] = 10'(r_pr);
        w_tdata[67:58] = 10'(r_pc);
        w_tlast = r_last;
    end

    assign s_axis_tready = (r_state == hmng_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == hmng_pkg::ST_OUT);
    assign m_axis_tdata  = w_tdata;
    assign m_axis_tlast  = w_tlast;

    `ASSERT_IMPL(a_no_busy_idle, i_clk, i_rst_n, r_state == hmng_pkg::ST_IDLE, !w_rsp.busy || w_rsp.done, "core: unit busy while idle")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "core: result dropped")
    `ASSERT_IMPL(a_pos_range, i_clk, i_rst_n, m_axis_tvalid, r_pr < w_rows && r_pc < w_cols, "core: point outside map")
endmodule
